### src/blfb_pkg.sv
// shared widths, command codes and display defaults for the line framebuffer core
// no dependencies
`timescale 1ns / 1ps

package blfb_pkg;

  // command field widths, fixed by the command word
  localparam int FUNC_W = 2;
  localparam int X_W    = 7;
  localparam int Y_W    = 6;
  localparam int BA_W   = 10;
  localparam int DATA_W = 8;

  // page layout: eight rows per byte
  localparam int PAGE_ROWS  = 8;
  localparam int PAGE_SHIFT = 3;

  // bresenham error term, covers twice the largest delta with sign
  localparam int ACC_W = 10;

  // default display size
  localparam int DEF_DISP_WIDTH  = 128;
  localparam int DEF_DISP_HEIGHT = 64;

  // command codes
  localparam logic [FUNC_W-1:0] FUNC_LINE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PIXEL = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

endpackage

### src/bresenham_line_framebuffer_core.sv
// line drawing core around a page-layout 1bpp framebuffer memory
// depends on blfb_pkg
`timescale 1ns / 1ps

// usage
//   command channel: drive func_i and the coordinate / address fields with start
//   high; the word is taken at a rising edge where start is high and busy is low.
//   result channel: done_o is high for exactly one cycle with read_data_o; the
//   receiver cannot stall it, so the word must be captured in that cycle.
//   every command gives exactly one result word (zero unless it is a byte read).
// sequencing
//   unused func code or read beyond the store: result in the cycle after accept
//   byte read: a memory read state, then the result register
//   pixel and line: a read state then a modify/write state for each pixel on
//   the line, result the cycle after the last write back; a longest line has
//   128 pixels. both states of a pixel use the single framebuffer memory.
//   a new command may be taken in the cycle its predecessor's result shows.
// reset
//   after reset the core sweeps the framebuffer to zero, one byte per cycle,
//   DISP_WIDTH*ceil(DISP_HEIGHT/8) bytes (1024 at the default size), with busy
//   held high; no command is taken during the sweep.
module bresenham_line_framebuffer_core
  import blfb_pkg::*;
#(
  parameter int DISP_WIDTH  = DEF_DISP_WIDTH,
  parameter int DISP_HEIGHT = DEF_DISP_HEIGHT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [FUNC_W-1:0] func_i,
  input  logic [X_W-1:0]    start_x_i,
  input  logic [Y_W-1:0]    start_y_i,
  input  logic [X_W-1:0]    end_x_i,
  input  logic [Y_W-1:0]    end_y_i,
  input  logic              pixel_on_i,
  input  logic [BA_W-1:0]   byte_addr_i,
  output logic              done_o,
  output logic [DATA_W-1:0] read_data_o
);

  localparam int PAGE_COUNT  = (DISP_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int STORE_BYTES = DISP_WIDTH * PAGE_COUNT;
  localparam int AW          = $clog2(STORE_BYTES);
  // compare widths wide enough for both the field and the display bound
  localparam int WX_W  = ($clog2(DISP_WIDTH + 1) > X_W) ? $clog2(DISP_WIDTH + 1) : X_W;
  localparam int WY_W  = ($clog2(DISP_HEIGHT + 1) > Y_W) ? $clog2(DISP_HEIGHT + 1) : Y_W;
  localparam int CMP_W = (AW + 1 > BA_W) ? AW + 1 : BA_W;
  localparam int IDX_W = Y_W - PAGE_SHIFT + WX_W + 1;

  // controller states
  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_PIX_RD  = 3'd2;
  localparam logic [2:0] ST_PIX_WR  = 3'd3;
  localparam logic [2:0] ST_BYTE_RD = 3'd4;

  logic [2:0] state_q, state_d;

  // framebuffer memory, one write port and one registered read port
  logic [DATA_W-1:0] mem [STORE_BYTES];
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_wa, mem_ra;
  logic [DATA_W-1:0] mem_wd, mem_rd_q;

  // clearing sweep
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;

  // line walker
  logic [X_W-1:0]          x_q, x_d, ex_q, ex_d;
  logic [Y_W-1:0]          y_q, y_d, ey_q, ey_d;
  logic signed [ACC_W-1:0] acc_q, acc_d, dx_q, dx_d, ddy_q, ddy_d;
  logic                    stx_neg_q, stx_neg_d, sty_neg_q, sty_neg_d;
  logic                    on_q, on_d;

  // result
  logic              done_q, done_d;
  logic [DATA_W-1:0] data_q, data_d;

  // command decode
  logic                    accept;
  logic [X_W-1:0]          cmd_ex, abs_dx;
  logic [Y_W-1:0]          cmd_ey, abs_dy;
  logic signed [ACC_W-1:0] dx_s, dy_s;
  logic                    rd_ok;

  // current pixel address
  logic             pix_ok;
  logic [IDX_W-1:0] idx_wide;
  logic [AW-1:0]    pix_idx;
  logic [DATA_W-1:0] pix_mask;

  // bresenham step
  logic signed [ACC_W:0]   twice;
  logic                    step_x, step_y, at_end;
  logic signed [ACC_W-1:0] acc_step;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  // a single pixel is a line whose end is its start
  always_comb begin
    if (func_i == FUNC_LINE) begin
      cmd_ex = end_x_i;
      cmd_ey = end_y_i;
    end else begin
      cmd_ex = start_x_i;
      cmd_ey = start_y_i;
    end
  end

  assign abs_dx = (cmd_ex >= start_x_i) ? cmd_ex - start_x_i : start_x_i - cmd_ex;
  assign abs_dy = (cmd_ey >= start_y_i) ? cmd_ey - start_y_i : start_y_i - cmd_ey;
  assign dx_s   = ACC_W'(abs_dx);
  assign dy_s   = ACC_W'(abs_dy);
  assign rd_ok  = CMP_W'(byte_addr_i) < CMP_W'(STORE_BYTES);

  // pixels off a smaller display are walked but not written
  assign pix_ok   = (WX_W'(x_q) < WX_W'(DISP_WIDTH)) && (WY_W'(y_q) < WY_W'(DISP_HEIGHT));
  assign idx_wide = IDX_W'(y_q[Y_W-1:PAGE_SHIFT]) * IDX_W'(DISP_WIDTH) + IDX_W'(x_q);
  assign pix_idx  = idx_wide[AW-1:0];
  assign pix_mask = DATA_W'(1) << y_q[PAGE_SHIFT-1:0];

  assign twice    = $signed({acc_q, 1'b0});
  assign step_x   = twice >= (ACC_W + 1)'(ddy_q);
  assign step_y   = twice <= (ACC_W + 1)'(dx_q);
  assign at_end   = (x_q == ex_q) && (y_q == ey_q);
  assign acc_step = acc_q + (step_x ? ddy_q : '0) + (step_y ? dx_q : '0);

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    x_d       = x_q;
    y_d       = y_q;
    ex_d      = ex_q;
    ey_d      = ey_q;
    acc_d     = acc_q;
    dx_d      = dx_q;
    ddy_d     = ddy_q;
    stx_neg_d = stx_neg_q;
    sty_neg_d = sty_neg_q;
    on_d      = on_q;
    done_d    = 1'b0;
    data_d    = data_q;
    mem_we    = 1'b0;
    mem_wa    = pix_idx;
    mem_wd    = '0;
    mem_re    = 1'b0;
    mem_ra    = pix_idx;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wa    = clr_cnt_q;
        clr_cnt_d = clr_cnt_q + AW'(1);
        if (clr_cnt_q == AW'(STORE_BYTES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (func_i)
            FUNC_LINE, FUNC_PIXEL: begin
              x_d       = start_x_i;
              y_d       = start_y_i;
              ex_d      = cmd_ex;
              ey_d      = cmd_ey;
              dx_d      = dx_s;
              ddy_d     = -dy_s;
              acc_d     = dx_s - dy_s;
              stx_neg_d = !(start_x_i < cmd_ex);
              sty_neg_d = !(start_y_i < cmd_ey);
              on_d      = pixel_on_i;
              state_d   = ST_PIX_RD;
            end
            FUNC_READ: begin
              if (rd_ok) begin
                mem_re  = 1'b1;
                mem_ra  = AW'(CMP_W'(byte_addr_i));
                state_d = ST_BYTE_RD;
              end else begin
                done_d = 1'b1;
                data_d = '0;
              end
            end
            default: begin
              // unused code: nothing changes, zero word back
              done_d = 1'b1;
              data_d = '0;
            end
          endcase
        end
      end
      ST_PIX_RD: begin
        mem_re  = pix_ok;
        state_d = ST_PIX_WR;
      end
      ST_PIX_WR: begin
        mem_we = pix_ok;
        mem_wd = on_q ? (mem_rd_q | pix_mask) : (mem_rd_q & ~pix_mask);
        if (at_end) begin
          done_d  = 1'b1;
          data_d  = '0;
          state_d = ST_IDLE;
        end else begin
          acc_d = acc_step;
          if (step_x) begin
            x_d = stx_neg_q ? x_q - X_W'(1) : x_q + X_W'(1);
          end
          if (step_y) begin
            y_d = sty_neg_q ? y_q - Y_W'(1) : y_q + Y_W'(1);
          end
          state_d = ST_PIX_RD;
        end
      end
      ST_BYTE_RD: begin
        done_d  = 1'b1;
        data_d  = mem_rd_q;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_rd_q <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      done_q    <= done_d;
    end
  end

  // walker and result payload, no reset needed
  always_ff @(posedge clk_i) begin
    x_q       <= x_d;
    y_q       <= y_d;
    ex_q      <= ex_d;
    ey_q      <= ey_d;
    acc_q     <= acc_d;
    dx_q      <= dx_d;
    ddy_q     <= ddy_d;
    stx_neg_q <= stx_neg_d;
    sty_neg_q <= sty_neg_d;
    on_q      <= on_d;
    data_q    <= data_d;
  end

  assign done_o      = done_q;
  assign read_data_o = data_q;

endmodule

### src/blfb_checker.sv
// port-level checks for the line framebuffer core, bound to its top level
// depends on blfb_pkg and bresenham_line_framebuffer_core
`timescale 1ns / 1ps

module blfb_checker
  import blfb_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic [FUNC_W-1:0] func_i,
  input logic              done_o,
  input logic [DATA_W-1:0] read_data_o
);

  logic              accept;
  logic              pending_q;
  logic [FUNC_W-1:0] last_func_q;

  assign accept = start && !busy;

  // one outstanding command at a time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= 1'b0;
      last_func_q <= FUNC_READ;
    end else begin
      if (accept) begin
        pending_q   <= 1'b1;
        last_func_q <= func_i;
      end else if (done_o) begin
        pending_q <= 1'b0;
      end
    end
  end

  // an accepted word is answered at once or keeps the core busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy || done_o))
    else $error("core idle after accept with no result");

  // no result without a command behind it
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> pending_q)
    else $error("result with no outstanding command");

  // no second command while the first is still open
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (!pending_q || done_o))
    else $error("command taken while another is outstanding");

  // only byte reads return nonzero data
  a_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (last_func_q != FUNC_READ)) |-> (read_data_o == '0))
    else $error("nonzero data for a non-read command");

endmodule

bind bresenham_line_framebuffer_core blfb_checker u_blfb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .func_i      (func_i),
  .done_o      (done_o),
  .read_data_o (read_data_o)
);

### verif/tb_top.sv
// self-checking bench for the line drawing framebuffer core
// depends on blfb_pkg and bresenham_line_framebuffer_core
`timescale 1ns / 1ps

module tb_top;
  import blfb_pkg::*;

  localparam int DISP_W      = DEF_DISP_WIDTH;
  localparam int DISP_H      = DEF_DISP_HEIGHT;
  localparam int PAGES       = (DISP_H + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int STORE_BYTES = DISP_W * PAGES;
  // unused command code, no name for it in the package
  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
  // idle cycles before the watchdog gives up: covers the clearing sweep,
  // a longest line and a longest sender gap several times over
  localparam int STALL_LIMIT = 8000;
  localparam int MAX_PRINTS  = 50;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [FUNC_W-1:0] func_i;
  logic [X_W-1:0]    start_x_i;
  logic [Y_W-1:0]    start_y_i;
  logic [X_W-1:0]    end_x_i;
  logic [Y_W-1:0]    end_y_i;
  logic              pixel_on_i;
  logic [BA_W-1:0]   byte_addr_i;
  logic              done_o;
  logic [DATA_W-1:0] read_data_o;

  // shadow copy of the framebuffer, updated when a command word is taken
  logic [DATA_W-1:0] fb_shadow [STORE_BYTES];
  // result bytes still owed by the core, oldest first
  logic [DATA_W-1:0] expected_bytes [$];
  logic [DATA_W-1:0] want_byte;

  int err_count;
  int stall_cnt;
  int n_lines, n_pixels, n_reads, n_unused, n_results;
  bit burst_mode;
  // byte touched most recently, reads aim there often
  int hot_addr;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  bresenham_line_framebuffer_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .func_i      (func_i),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .pixel_on_i  (pixel_on_i),
    .byte_addr_i (byte_addr_i),
    .done_o      (done_o),
    .read_data_o (read_data_o)
  );

  task automatic report_mismatch(input string msg);
    if (err_count < MAX_PRINTS) $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // predictor: page layout, bit y mod 8 of byte (y/8)*width + x
  // ---------------------------------------------------------------------------
  function automatic void shadow_plot(input int x, input int y, input bit on);
    int idx;
    if (x < 0 || x >= DISP_W || y < 0 || y >= DISP_H) return;
    idx = (y / PAGE_ROWS) * DISP_W + x;
    if (idx >= STORE_BYTES) return;
    if (on) fb_shadow[idx] = fb_shadow[idx] | (8'd1 << (y % PAGE_ROWS));
    else    fb_shadow[idx] = fb_shadow[idx] & ~(8'd1 << (y % PAGE_ROWS));
    hot_addr = idx;
  endfunction

  // integer bresenham, both ends included
  function automatic void shadow_line(input int xa, input int ya, input int xb,
                                      input int yb, input bit on);
    int ddx, ddy, stx, sty, acc, twice;
    ddx = (xb >= xa) ? xb - xa : xa - xb;
    ddy = -((yb >= ya) ? yb - ya : ya - yb);
    stx = (xa < xb) ? 1 : -1;
    sty = (ya < yb) ? 1 : -1;
    acc = ddx + ddy;
    while (1'b1) begin
      shadow_plot(xa, ya, on);
      if (xa == xb && ya == yb) break;
      twice = 2 * acc;
      if (twice >= ddy) begin
        acc += ddy;
        xa  += stx;
      end
      if (twice <= ddx) begin
        acc += ddx;
        ya  += sty;
      end
    end
  endfunction

  // applies one command word to the shadow and gives the byte it returns
  function automatic logic [DATA_W-1:0] shadow_command(
    input logic [FUNC_W-1:0] fn, input logic [X_W-1:0] sx, input logic [Y_W-1:0] sy,
    input logic [X_W-1:0] ex, input logic [Y_W-1:0] ey, input logic on,
    input logic [BA_W-1:0] addr);
    logic [DATA_W-1:0] data;
    data = '0;
    case (fn)
      FUNC_LINE:  shadow_line(int'(sx), int'(sy), int'(ex), int'(ey), on);
      FUNC_PIXEL: shadow_plot(int'(sx), int'(sy), on);
      FUNC_READ: begin
        if (int'(addr) < STORE_BYTES) data = fb_shadow[addr];
      end
      default: data = '0;
    endcase
    return data;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: one command word, after an idle gap; returns at the accepting edge
  // with start still high so back-to-back words need no extra assignment
  // ---------------------------------------------------------------------------
  task automatic send_cmd(input logic [FUNC_W-1:0] fn, input logic [X_W-1:0] sx,
                          input logic [Y_W-1:0] sy, input logic [X_W-1:0] ex,
                          input logic [Y_W-1:0] ey, input logic on,
                          input logic [BA_W-1:0] addr, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start       <= 1'b1;
    func_i      <= fn;
    start_x_i   <= sx;
    start_y_i   <= sy;
    end_x_i     <= ex;
    end_y_i     <= ey;
    pixel_on_i  <= on;
    byte_addr_i <= addr;
    do @(posedge clk_i); while (busy !== 1'b0);
    // the word was taken at this edge
    expected_bytes.push_back(shadow_command(fn, sx, sy, ex, ey, on, addr));
    case (fn)
      FUNC_LINE:  n_lines++;
      FUNC_PIXEL: n_pixels++;
      FUNC_READ:  n_reads++;
      default:    n_unused++;
    endcase
  endtask

  function automatic int pick_gap();
    return burst_mode ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic logic [BA_W-1:0] addr_of(input int x, input int y);
    return BA_W'((y / PAGE_ROWS) * DISP_W + x);
  endfunction

  // ---------------------------------------------------------------------------
  // result checker: the receiver cannot stall, so every done cycle is a word
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      n_results++;
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("result word 0x%02h with nothing pending", read_data_o));
      end else begin
        want_byte = expected_bytes.pop_front();
        if (read_data_o !== want_byte)
          report_mismatch($sformatf("read_data got 0x%02h want 0x%02h",
                                    read_data_o, want_byte));
      end
    end
  end

  // watchdog on cycles with neither an accepted command nor a result
  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1) begin
      stall_cnt <= 0;
    end else if ((start === 1'b1 && busy === 1'b0) || done_o === 1'b1) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("timeout: no progress for %0d cycles, %0d words pending",
                 STALL_LIMIT, expected_bytes.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------------------

  // store must read back zero after the clearing sweep
  task automatic test_reset_clear();
    send_cmd(FUNC_READ, '0, '0, '0, '0, 1'b0, '0, 0);
    send_cmd(FUNC_READ, '1, '1, '1, '1, 1'b1, BA_W'(STORE_BYTES - 1), pick_gap());
    send_cmd(FUNC_READ, 7'h55, 6'h2a, 7'h2a, 6'h15, 1'b1, 10'h2aa, pick_gap());
  endtask

  // single pixels at the corners, then one cleared again
  task automatic test_single_pixels();
    send_cmd(FUNC_PIXEL, 7'd0,   6'd0,  '1, '1, 1'b1, '1, pick_gap());
    send_cmd(FUNC_PIXEL, 7'd127, 6'd63, '0, '0, 1'b1, '0, pick_gap());
    send_cmd(FUNC_PIXEL, 7'd127, 6'd0,  '0, '1, 1'b1, '0, 0);
    send_cmd(FUNC_PIXEL, 7'd0,   6'd63, '1, '0, 1'b1, '1, 0);
    send_cmd(FUNC_READ, '0, '0, '0, '0, 1'b0, addr_of(0, 0), pick_gap());
    send_cmd(FUNC_READ, '0, '0, '0, '0, 1'b0, addr_of(127, 63), 0);
    send_cmd(FUNC_READ, '0, '0, '0, '0, 1'b0, addr_of(127, 0), pick_gap());
    send_cmd(FUNC_READ, '0, '0, '0, '0, 1'b0, addr_of(0, 63), 0);
    send_cmd(FUNC_PIXEL, 7'd127, 6'd63, '0, '0, 1'b0, '0, pick_gap());
    send_cmd(FUNC_READ, '0, '0, '0, '0, 1'b0, addr_of(127, 63), 0);
  endtask

  // single point, a full-width and a full-height line, diagonal both ways, and an erasing line
  task automatic test_line_shapes();
    send_cmd(FUNC_LINE, 7'd40,  6'd20, 7'd40, 6'd20, 1'b1, '0, pick_gap());
    send_cmd(FUNC_READ, '0, '0, '0, '0, 1'b0, addr_of(40, 20), 0);
    send_cmd(FUNC_LINE, 7'd0,   6'd8,  7'd127, 6'd8, 1'b1, '0, pick_gap());
    send_cmd(FUNC_LINE, 7'd100, 6'd63, 7'd100, 6'd0, 1'b1, '0, 0);
    send_cmd(FUNC_LINE, 7'd127, 6'd63, 7'd0,   6'd0, 1'b1, '0, pick_gap());
    send_cmd(FUNC_LINE, 7'd0,   6'd63, 7'd127, 6'd0, 1'b1, '0, 0);
    send_cmd(FUNC_READ, '0, '0, '0, '0, 1'b0, addr_of(64, 32), pick_gap());
    send_cmd(FUNC_LINE, 7'd127, 6'd8,  7'd0,   6'd8, 1'b0, '1, 0);
    send_cmd(FUNC_READ, '0, '0, '0, '0, 1'b0, addr_of(100, 8), 0);
  endtask

  // unused code changes nothing and returns zero
  task automatic test_unused_func();
    send_cmd(FUNC_NONE, 7'd40, 6'd20, 7'd0, 6'd0, 1'b0, addr_of(40, 20), pick_gap());
    send_cmd(FUNC_NONE, '1, '1, '1, '1, 1'b1, '1, 0);
    send_cmd(FUNC_READ, '0, '0, '0, '0, 1'b0, addr_of(40, 20), pick_gap());
  endtask

  // ---------------------------------------------------------------------------
  // random mix: mostly short lines and pixels, with frequent reads aimed at
  // bytes just drawn so that the shadow really gets compared
  // ---------------------------------------------------------------------------
  task automatic test_random_mix(input int count);
    int sel, cx, cy, ex, ey;
    logic [FUNC_W-1:0] fn;
    logic [BA_W-1:0] addr;
    for (int i = 0; i < count; i++) begin
      // alternate paced and back-to-back stretches
      if (i % 50 == 0) burst_mode = $urandom_range(0, 2) == 0;
      sel  = $urandom_range(0, 99);
      cx   = $urandom_range(0, DISP_W - 1);
      cy   = $urandom_range(0, DISP_H - 1);
      ex   = $urandom_range(0, DISP_W - 1);
      ey   = $urandom_range(0, DISP_H - 1);
      addr = BA_W'($urandom_range(0, STORE_BYTES - 1));
      if (sel < 30) begin
        fn = FUNC_LINE;
        // short lines around the start point most of the time
        if ($urandom_range(0, 9) < 7) begin
          ex = cx + $urandom_range(0, 16) - 8;
          ey = cy + $urandom_range(0, 16) - 8;
          if (ex < 0) ex = 0;
          if (ex > DISP_W - 1) ex = DISP_W - 1;
          if (ey < 0) ey = 0;
          if (ey > DISP_H - 1) ey = DISP_H - 1;
        end
      end else if (sel < 55) begin
        fn = FUNC_PIXEL;
      end else if (sel < 96) begin
        fn = FUNC_READ;
        if ($urandom_range(0, 1) == 1) addr = BA_W'(hot_addr);
      end else begin
        fn = FUNC_NONE;
      end
      send_cmd(fn, X_W'(cx), Y_W'(cy), X_W'(ex), Y_W'(ey), 1'($urandom_range(0, 1)),
               addr, pick_gap());
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    func_i      = '0;
    start_x_i   = '0;
    start_y_i   = '0;
    end_x_i     = '0;
    end_y_i     = '0;
    pixel_on_i  = 1'b0;
    byte_addr_i = '0;
    err_count   = 0;
    n_lines     = 0;
    n_pixels    = 0;
    n_reads     = 0;
    n_unused    = 0;
    n_results   = 0;
    hot_addr    = 0;
    burst_mode  = 1'b0;
    foreach (fb_shadow[i]) fb_shadow[i] = '0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // the core sweeps the store after reset, send_cmd waits on busy for it
    @(posedge clk_i);

    test_reset_clear();
    test_single_pixels();
    test_line_shapes();
    test_unused_func();
    test_random_mix(1150);

    start <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (expected_bytes.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", expected_bytes.size()));

    $display("covered %0d lines, %0d pixel writes, %0d byte reads, %0d unused codes",
             n_lines, n_pixels, n_reads, n_unused);
    $display("%0d result words checked, %0d mismatches", n_results, err_count);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### bresenham_line_framebuffer_core.f
src/blfb_pkg.sv
src/bresenham_line_framebuffer_core.sv
src/blfb_checker.sv
verif/tb_top.sv
